/* rtl/reduction_tree_parent_index_macros.svh */
// Assertion macros for the reduction tree parent lookup.
`ifndef REDUCTION_TREE_PARENT_INDEX_MACROS_SVH
`define REDUCTION_TREE_PARENT_INDEX_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RTPI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTPI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rtpi_pkg.sv */
`default_nettype none

package rtpi_pkg;

  localparam int NODE_W = 11;
  localparam int RANK_W = 11;
  localparam int PAR_W  = 10;
  localparam int RNG_W  = 12;
  localparam int CMP_W  = 13;

  localparam int unsigned MAX_RANKS_DEF = 1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LCHK,
    ST_CLIMB,
    ST_WALK,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RNG_HOLD,
    RNG_LOAD,
    RNG_UP
  } rng_op_t;

  typedef enum logic [1:0] {
    P_HOLD,
    P_FROM_ID,
    P_UP
  } p_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_PLAIN,
    RES_ROOT,
    RES_ERR,
    RES_P,
    RES_ZERO
  } res_sel_t;

  typedef struct packed {
    logic     id_load;
    rng_op_t  rng_op;
    p_op_t    p_op;
    res_sel_t res_sel;
    logic     out_load;
  } rtpi_cmd_t;

  typedef struct packed {
    logic id_zero;
    logic in_range;
    logic id_eq_hi;
    logic id_lt_lo;
    logic id_gt_hi;
    logic id_lt_hi;
    logic hi_zero;
    logic leaf_in;
    logic ok;
    logic p_zero;
    logic p_up_zero;
    logic out_free;
  } rtpi_status_t;

  function automatic logic [RNG_W-1:0] up_rng(input logic [RNG_W-1:0] n);
    logic [RNG_W-1:0] m;
    m = n - RNG_W'(1);
    return (n == '0) ? '0 : (m >> 1);
  endfunction

  function automatic logic [RNG_W-1:0] slots_of(input logic [RANK_W-1:0] rc);
    logic [RNG_W-1:0] s;
    logic             found;
    s = '0;
    found = 1'b0;
    for (int k = 0; k < RNG_W; k++) begin
      if (!found && ((RNG_W'(1) << k) >= RNG_W'(rc))) begin
        s = RNG_W'(1) << k;
        found = 1'b1;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/rtpi_ctrl.sv */
`default_nettype none

module rtpi_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rtpi_pkg::rtpi_status_t status,
  output rtpi_pkg::rtpi_cmd_t        cmd
);

  rtpi_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rtpi_pkg::ST_IDLE: begin
        if (in_valid) state_next = rtpi_pkg::ST_SCAN;
      end
      rtpi_pkg::ST_SCAN: begin
        priority if (status.id_zero || status.in_range) state_next = rtpi_pkg::ST_OUT;
        else if (status.id_eq_hi) state_next = rtpi_pkg::ST_LCHK;
        else if (status.id_lt_lo) state_next = rtpi_pkg::ST_SCAN;
        else state_next = rtpi_pkg::ST_OUT;
      end
      rtpi_pkg::ST_LCHK: begin
        state_next = status.id_gt_hi ? rtpi_pkg::ST_OUT : rtpi_pkg::ST_CLIMB;
      end
      rtpi_pkg::ST_CLIMB: begin
        priority if (status.id_lt_hi && !status.hi_zero) state_next = rtpi_pkg::ST_CLIMB;
        else if (!status.leaf_in || status.id_zero) state_next = rtpi_pkg::ST_OUT;
        else state_next = rtpi_pkg::ST_WALK;
      end
      rtpi_pkg::ST_WALK: begin
        if (status.ok || status.p_zero || status.p_up_zero) state_next = rtpi_pkg::ST_OUT;
      end
      rtpi_pkg::ST_OUT: begin
        if (status.out_free) state_next = rtpi_pkg::ST_IDLE;
      end
      default: state_next = rtpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.id_load  = 1'b0;
    cmd.rng_op   = rtpi_pkg::RNG_HOLD;
    cmd.p_op     = rtpi_pkg::P_HOLD;
    cmd.res_sel  = rtpi_pkg::RES_NONE;
    cmd.out_load = 1'b0;
    unique case (state)
      rtpi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.id_load = 1'b1;
          cmd.rng_op  = rtpi_pkg::RNG_LOAD;
        end
      end
      rtpi_pkg::ST_SCAN: begin
        priority if (status.id_zero) cmd.res_sel = rtpi_pkg::RES_ROOT;
        else if (status.in_range) cmd.res_sel = rtpi_pkg::RES_PLAIN;
        else if (status.id_eq_hi) cmd.rng_op = rtpi_pkg::RNG_LOAD;
        else if (status.id_lt_lo) cmd.rng_op = rtpi_pkg::RNG_UP;
        else cmd.res_sel = rtpi_pkg::RES_PLAIN;
      end
      rtpi_pkg::ST_LCHK: begin
        if (status.id_gt_hi) cmd.res_sel = rtpi_pkg::RES_ERR;
      end
      rtpi_pkg::ST_CLIMB: begin
        priority if (status.id_lt_hi && !status.hi_zero) cmd.rng_op = rtpi_pkg::RNG_UP;
        else if (!status.leaf_in || status.id_zero) cmd.res_sel = rtpi_pkg::RES_ERR;
        else cmd.p_op = rtpi_pkg::P_FROM_ID;
      end
      rtpi_pkg::ST_WALK: begin
        priority if (status.ok || status.p_zero) cmd.res_sel = rtpi_pkg::RES_P;
        else if (status.p_up_zero) cmd.res_sel = rtpi_pkg::RES_ZERO;
        else begin
          cmd.p_op   = rtpi_pkg::P_UP;
          cmd.rng_op = rtpi_pkg::RNG_UP;
        end
      end
      rtpi_pkg::ST_OUT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rtpi_dp.sv */
`default_nettype none

module rtpi_dp #(
  parameter int unsigned MAX_RANKS = rtpi_pkg::MAX_RANKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rtpi_pkg::RANK_W-1:0] cfg_wr_data,
  input  wire logic [rtpi_pkg::NODE_W-1:0] node_index,
  input  wire rtpi_pkg::rtpi_cmd_t         cmd,
  output rtpi_pkg::rtpi_status_t           status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rtpi_pkg::PAR_W-1:0]       parent_index,
  output logic                             is_root,
  output logic                             range_error
);

  logic [rtpi_pkg::RANK_W-1:0] rank_count;
  logic [rtpi_pkg::RANK_W-1:0] rc_lim;
  logic [rtpi_pkg::RNG_W-1:0]  slots;
  logic [rtpi_pkg::RNG_W-1:0]  lo_init;
  logic [rtpi_pkg::RNG_W-1:0]  hi_init;

  logic [rtpi_pkg::NODE_W-1:0] id;
  logic [rtpi_pkg::RNG_W-1:0]  lo;
  logic [rtpi_pkg::RNG_W-1:0]  hi;
  logic [rtpi_pkg::PAR_W-1:0]  p;
  logic [rtpi_pkg::PAR_W-1:0]  res_parent;
  logic                        res_root;
  logic                        res_err;

  logic [rtpi_pkg::RNG_W-1:0]  id_x;
  logic [rtpi_pkg::PAR_W-1:0]  id_up;
  logic [rtpi_pkg::PAR_W-1:0]  p_up;
  logic [rtpi_pkg::CMP_W-1:0]  left_c;
  logic [rtpi_pkg::CMP_W-1:0]  right_c;

  always_comb begin
    priority if (rank_count == '0) rc_lim = rtpi_pkg::RANK_W'(1);
    else if (32'(rank_count) > 32'(MAX_RANKS)) rc_lim = rtpi_pkg::RANK_W'(MAX_RANKS);
    else rc_lim = rank_count;
  end

  assign slots   = rtpi_pkg::slots_of(rc_lim);
  assign lo_init = slots - rtpi_pkg::RNG_W'(1);
  assign hi_init = slots + rtpi_pkg::RNG_W'(rc_lim) - rtpi_pkg::RNG_W'(2);

  assign id_x    = rtpi_pkg::RNG_W'(id);
  assign id_up   = rtpi_pkg::PAR_W'(rtpi_pkg::up_rng(id_x));
  assign p_up    = rtpi_pkg::PAR_W'(rtpi_pkg::up_rng(rtpi_pkg::RNG_W'(p)));
  assign left_c  = {2'b00, p, 1'b1};
  assign right_c = left_c + rtpi_pkg::CMP_W'(1);

  always_comb begin
    status.id_zero   = (id == '0);
    status.in_range  = (lo <= id_x) && (id_x < hi);
    status.id_eq_hi  = (id_x == hi);
    status.id_lt_lo  = (id_x < lo);
    status.id_gt_hi  = (id_x > hi);
    status.id_lt_hi  = (id_x < hi);
    status.hi_zero   = (hi == '0);
    status.leaf_in   = (lo <= id_x) && (id_x <= hi);
    status.ok        = (rtpi_pkg::CMP_W'(lo) <= left_c) && (right_c <= rtpi_pkg::CMP_W'(hi));
    status.p_zero    = (p == '0);
    status.p_up_zero = (p_up == '0);
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= rtpi_pkg::RANK_W'(1);
    end else if (cfg_wr_en) begin
      rank_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.id_load) id <= node_index;

    unique case (cmd.rng_op)
      rtpi_pkg::RNG_LOAD: begin
        lo <= lo_init;
        hi <= hi_init;
      end
      rtpi_pkg::RNG_UP: begin
        lo <= rtpi_pkg::up_rng(lo);
        hi <= rtpi_pkg::up_rng(hi);
      end
      default: begin
        lo <= lo;
        hi <= hi;
      end
    endcase

    unique case (cmd.p_op)
      rtpi_pkg::P_FROM_ID: p <= id_up;
      rtpi_pkg::P_UP:      p <= p_up;
      default:             p <= p;
    endcase

    unique case (cmd.res_sel)
      rtpi_pkg::RES_PLAIN: begin
        res_parent <= id_up;
        res_root   <= 1'b0;
        res_err    <= 1'b0;
      end
      rtpi_pkg::RES_ROOT: begin
        res_parent <= '0;
        res_root   <= 1'b1;
        res_err    <= 1'b0;
      end
      rtpi_pkg::RES_ERR: begin
        res_parent <= '0;
        res_root   <= 1'b0;
        res_err    <= 1'b1;
      end
      rtpi_pkg::RES_P: begin
        res_parent <= p;
        res_root   <= 1'b0;
        res_err    <= 1'b0;
      end
      rtpi_pkg::RES_ZERO: begin
        res_parent <= '0;
        res_root   <= 1'b0;
        res_err    <= 1'b0;
      end
      default: begin
        res_parent <= res_parent;
        res_root   <= res_root;
        res_err    <= res_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      parent_index <= res_parent;
      is_root      <= res_root;
      range_error  <= res_err;
    end
  end

endmodule

`default_nettype wire

/* rtl/reduction_tree_parent_index.sv */
// The time from an accepted input word to output valid is set by the level scan,
// the upward climb and the ancestor walk, one tree level a cycle.
// Words are handled one at a time; the next word is taken once the result has
// moved to the output register, which holds it until taken.
// Reset (rst, synchronous): rank count returns to 1, controller goes idle,
// output valid drops.
`default_nettype none
`include "reduction_tree_parent_index_macros.svh"

module reduction_tree_parent_index #(
  parameter int unsigned MAX_RANKS = rtpi_pkg::MAX_RANKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rtpi_pkg::RANK_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rtpi_pkg::NODE_W-1:0] node_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rtpi_pkg::PAR_W-1:0]       parent_index,
  output logic                             is_root,
  output logic                             range_error
);

  rtpi_pkg::rtpi_cmd_t    cmd;
  rtpi_pkg::rtpi_status_t status;

  rtpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rtpi_dp #(
    .MAX_RANKS (MAX_RANKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .node_index   (node_index),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parent_index (parent_index),
    .is_root      (is_root),
    .range_error  (range_error)
  );

  `RTPI_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word taken while busy")
  `RTPI_ASSERT_NOW(a_root_clean, out_valid && is_root, (parent_index == '0) && !range_error, "root word not clean")
  `RTPI_ASSERT_NOW(a_err_zero, out_valid && range_error, parent_index == '0, "error word has parent")
  `RTPI_ASSERT_NOW(a_load_free, cmd.out_load, status.out_free, "output overwritten")

endmodule

`default_nettype wire
